// ===== rtl/slkb_pkg.sv =====
// ----------------------------------------------------------------------------
// slkb_pkg
// shared types, constants and helpers of the sp hamiltonian block generator
// ----------------------------------------------------------------------------
package slkb_pkg;

    localparam int ATOM_COUNT  = 64;
    localparam int ENTRY_COUNT = 16;
    localparam int PAIR_STRIDE = 16 * ATOM_COUNT;
    localparam int ROW_STRIDE  = 4 * ATOM_COUNT;

    localparam int ATOM_W  = 6;
    localparam int COS_W   = 16;
    localparam int SQ_W    = 15;
    localparam int NRG_W   = 20;
    localparam int ADDR_W  = 16;
    localparam int IDX_W   = 4;

    localparam logic signed [NRG_W-1:0] VAL_MAX = 20'sh7FFFF;
    localparam logic signed [NRG_W-1:0] VAL_MIN = 20'sh80000;

    // configuration register indexes
    localparam logic REG_ONSITE_S = 1'b0;
    localparam logic REG_ONSITE_P = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

    typedef struct packed {
        logic        [ATOM_W-1:0] atom_row;
        logic        [ATOM_W-1:0] atom_col;
        logic signed [COS_W-1:0]  cos_x;
        logic signed [COS_W-1:0]  cos_y;
        logic signed [COS_W-1:0]  cos_z;
        logic        [SQ_W-1:0]   cos_x_sq;
        logic        [SQ_W-1:0]   cos_y_sq;
        logic        [SQ_W-1:0]   cos_z_sq;
        logic signed [NRG_W-1:0]  ss_sigma;
        logic signed [NRG_W-1:0]  sp_sigma;
        logic signed [NRG_W-1:0]  pp_sigma;
        logic signed [NRG_W-1:0]  pp_pi;
    } item_t;

    // one matrix entry to compute, issued by the sequencer
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        item_t            item;
    } token_t;

    // direction cosine of orbital px, py, pz (1..3)
    function automatic logic signed [COS_W-1:0] pick_cos(item_t it, logic [1:0] sel);
        logic signed [COS_W-1:0] res;
        unique case (sel)
            2'd1:    res = it.cos_x;
            2'd2:    res = it.cos_y;
            2'd3:    res = it.cos_z;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [SQ_W-1:0] pick_sq(item_t it, logic [1:0] sel);
        logic [SQ_W-1:0] res;
        unique case (sel)
            2'd1:    res = it.cos_x_sq;
            2'd2:    res = it.cos_y_sq;
            2'd3:    res = it.cos_z_sq;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/slkb_item_if.sv =====
// ----------------------------------------------------------------------------
// slkb_item_if
// atom pair channel: valid/ready with the pair geometry and bond integrals
// ----------------------------------------------------------------------------
interface slkb_item_if import slkb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [ATOM_W-1:0] atom_row;
    logic        [ATOM_W-1:0] atom_col;
    logic signed [COS_W-1:0]  cos_x;
    logic signed [COS_W-1:0]  cos_y;
    logic signed [COS_W-1:0]  cos_z;
    logic        [SQ_W-1:0]   cos_x_sq;
    logic        [SQ_W-1:0]   cos_y_sq;
    logic        [SQ_W-1:0]   cos_z_sq;
    logic signed [NRG_W-1:0]  ss_sigma;
    logic signed [NRG_W-1:0]  sp_sigma;
    logic signed [NRG_W-1:0]  pp_sigma;
    logic signed [NRG_W-1:0]  pp_pi;

    modport source (
        output valid, atom_row, atom_col, cos_x, cos_y, cos_z,
               cos_x_sq, cos_y_sq, cos_z_sq, ss_sigma, sp_sigma, pp_sigma, pp_pi,
        input  ready
    );

    modport sink (
        input  valid, atom_row, atom_col, cos_x, cos_y, cos_z,
               cos_x_sq, cos_y_sq, cos_z_sq, ss_sigma, sp_sigma, pp_sigma, pp_pi,
        output ready
    );
endinterface

// ----------------------------------------------------------------------------
// slkb_entry_if
// matrix entry channel: valid/ready with address, value and last flag
// ----------------------------------------------------------------------------
interface slkb_entry_if import slkb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [ADDR_W-1:0] matrix_address;
    logic signed [NRG_W-1:0]  element_value;
    logic                     last_entry;

    modport source (
        output valid, matrix_address, element_value, last_entry,
        input  ready
    );

    modport sink (
        input  valid, matrix_address, element_value, last_entry,
        output ready
    );
endinterface

// ===== rtl/slkb_issue.sv =====
// ----------------------------------------------------------------------------
// slkb_issue
// holds one atom pair and issues its sixteen entries, one per free cycle
// ----------------------------------------------------------------------------
module slkb_issue import slkb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    slkb_item_if.sink    item,
    input  logic         adv,
    output token_t       tok
);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    item_t            item_reg;
    logic             take;
    logic             accept;
    logic             is_last;

    assign is_last    = (idx_reg == LAST_IDX);
    assign take       = busy_reg && adv;
    assign item.ready = !busy_reg || (take && is_last);
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 1'b1;
            if (is_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // pair payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.atom_row <= item.atom_row;
            item_reg.atom_col <= item.atom_col;
            item_reg.cos_x    <= item.cos_x;
            item_reg.cos_y    <= item.cos_y;
            item_reg.cos_z    <= item.cos_z;
            item_reg.cos_x_sq <= item.cos_x_sq;
            item_reg.cos_y_sq <= item.cos_y_sq;
            item_reg.cos_z_sq <= item.cos_z_sq;
            item_reg.ss_sigma <= item.ss_sigma;
            item_reg.sp_sigma <= item.sp_sigma;
            item_reg.pp_sigma <= item.pp_sigma;
            item_reg.pp_pi    <= item.pp_pi;
        end
    end

    assign tok.valid = busy_reg;
    assign tok.idx   = idx_reg;
    assign tok.item  = item_reg;

endmodule

// ===== rtl/slater_koster_sp_block_unit.sv =====
// ----------------------------------------------------------------------------
// slater_koster_sp_block_unit
// slater-koster sp hamiltonian block: sixteen 4x4 entries per atom pair
// ----------------------------------------------------------------------------
//
//  channel   dir  kind            contents
//  item      in   valid/ready     atom pair, cosines, squares, bond integrals
//  entry     out  valid/ready     matrix address, element value, last flag
//  cfg       in   write only      on-site s and p energies
//
//  one entry per cycle while the entry channel is not stalling
//  a new pair is taken during the cycle the previous pair's last entry issues
//  after the pair transaction the first entry passes the issue register, the
//  select and multiply stages, the round add and the output register
//  rst_n clears valid bits, sequencer and energies; stalls freeze all stages
//
module slater_koster_sp_block_unit import slkb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    slkb_item_if.sink          item,
    slkb_entry_if.source       entry,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [NRG_W-1:0]   cfg_wdata
);

    localparam logic signed [53:0] RND14 = 54'sd8192;
    localparam logic signed [53:0] RND28 = 54'sd134217728;

    // on-site energies
    logic signed [NRG_W-1:0] es_reg;
    logic signed [NRG_W-1:0] ep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            es_reg <= '0;
            ep_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ONSITE_S: es_reg <= cfg_wdata;
                REG_ONSITE_P: ep_reg <= cfg_wdata;
            endcase
        end
    end

    // whole pipeline moves when the output register is free or being drained
    logic   adv;
    token_t tok;
    logic   vo_reg;

    assign adv = !vo_reg || entry.ready;

    slkb_issue u_issue (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .adv   (adv),
        .tok   (tok)
    );

    // ---------------- stage 1: operand select, cosine product, address
    logic        [1:0]        row, col;
    logic signed [COS_W-1:0]  c_row, c_col;
    logic        [SQ_W-1:0]   q_row;
    logic signed [20:0]       diff;
    logic signed [31:0]       f_next;
    logic signed [20:0]       g_next;
    logic signed [33:0]       add_next;
    logic                     sh28_next;
    logic signed [NRG_W-1:0]  oval_next;
    logic        [31:0]       addr_w;

    always_comb
    begin
        row   = tok.idx[3:2];
        col   = tok.idx[1:0];
        c_row = pick_cos(tok.item, row);
        c_col = pick_cos(tok.item, col);
        q_row = pick_sq(tok.item, row);
        diff  = 21'(tok.item.pp_sigma) - 21'(tok.item.pp_pi);

        f_next    = '0;
        g_next    = '0;
        add_next  = '0;
        sh28_next = 1'b0;
        priority if (row == 2'd0 && col == 2'd0)
        begin
            // ss entry: times one in q1.14, exact after rounding
            f_next = 32'sd16384;
            g_next = 21'(tok.item.ss_sigma);
        end
        else if (row == 2'd0)
        begin
            f_next = 32'(c_col);
            g_next = 21'(tok.item.sp_sigma);
        end
        else if (col == 2'd0)
        begin
            // p-s entry: negated product, rounded after negation
            f_next = -32'(c_row);
            g_next = 21'(tok.item.sp_sigma);
        end
        else if (row == col)
        begin
            f_next   = 32'(signed'({1'b0, q_row}));
            g_next   = diff;
            add_next = 34'(tok.item.pp_pi) <<< 14;
        end
        else
        begin
            f_next    = 32'(c_row) * 32'(c_col);
            g_next    = diff;
            sh28_next = 1'b1;
        end

        oval_next = '0;
        if (row == col)
            oval_next = (row == 2'd0) ? es_reg : ep_reg;

        addr_w = 32'(PAIR_STRIDE) * 32'(tok.item.atom_row)
               + 32'(4) * 32'(tok.item.atom_col)
               + 32'(ROW_STRIDE) * 32'(row) + 32'(col);
    end

    logic                     v1_reg;
    logic signed [31:0]       s1_f_reg;
    logic signed [20:0]       s1_g_reg;
    logic signed [33:0]       s1_add_reg;
    logic                     s1_sh28_reg;
    logic                     s1_onsite_reg;
    logic signed [NRG_W-1:0]  s1_oval_reg;
    logic        [ADDR_W-1:0] s1_addr_reg;
    logic                     s1_last_reg;

    // ---------------- stage 2: main product
    logic                     v2_reg;
    logic signed [52:0]       s2_prod_reg;
    logic signed [33:0]       s2_add_reg;
    logic                     s2_sh28_reg;
    logic                     s2_onsite_reg;
    logic signed [NRG_W-1:0]  s2_oval_reg;
    logic        [ADDR_W-1:0] s2_addr_reg;
    logic                     s2_last_reg;

    // ---------------- stage 3: add on-diagonal pi term and rounding bias
    logic                     v3_reg;
    logic signed [53:0]       s3_x_reg;
    logic                     s3_sh28_reg;
    logic                     s3_onsite_reg;
    logic signed [NRG_W-1:0]  s3_oval_reg;
    logic        [ADDR_W-1:0] s3_addr_reg;
    logic                     s3_last_reg;

    // ---------------- stage 4: shift, saturate, output register
    logic signed [53:0]       shifted;
    logic signed [NRG_W-1:0]  sat_val;
    logic signed [NRG_W-1:0]  val_next;
    logic signed [NRG_W-1:0]  vo_val_reg;
    logic        [ADDR_W-1:0] vo_addr_reg;
    logic                     vo_last_reg;

    always_comb
    begin
        shifted = s3_sh28_reg ? (s3_x_reg >>> 28) : (s3_x_reg >>> 14);
        if (shifted > 54'(VAL_MAX))
            sat_val = VAL_MAX;
        else if (shifted < 54'(VAL_MIN))
            sat_val = VAL_MIN;
        else
            sat_val = shifted[NRG_W-1:0];
        val_next = s3_onsite_reg ? s3_oval_reg : sat_val;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= tok.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // stage payloads, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_f_reg      <= f_next;
            s1_g_reg      <= g_next;
            s1_add_reg    <= add_next;
            s1_sh28_reg   <= sh28_next;
            s1_onsite_reg <= (tok.item.atom_row == tok.item.atom_col);
            s1_oval_reg   <= oval_next;
            s1_addr_reg   <= addr_w[ADDR_W-1:0];
            s1_last_reg   <= (tok.idx == LAST_IDX);

            s2_prod_reg   <= 53'(s1_f_reg) * 53'(s1_g_reg);
            s2_add_reg    <= s1_add_reg;
            s2_sh28_reg   <= s1_sh28_reg;
            s2_onsite_reg <= s1_onsite_reg;
            s2_oval_reg   <= s1_oval_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_last_reg   <= s1_last_reg;

            s3_x_reg      <= 54'(s2_prod_reg) + 54'(s2_add_reg)
                           + (s2_sh28_reg ? RND28 : RND14);
            s3_sh28_reg   <= s2_sh28_reg;
            s3_onsite_reg <= s2_onsite_reg;
            s3_oval_reg   <= s2_oval_reg;
            s3_addr_reg   <= s2_addr_reg;
            s3_last_reg   <= s2_last_reg;

            vo_val_reg    <= val_next;
            vo_addr_reg   <= s3_addr_reg;
            vo_last_reg   <= s3_last_reg;
        end
    end

    assign entry.valid          = vo_reg;
    assign entry.matrix_address = vo_addr_reg;
    assign entry.element_value  = vo_val_reg;
    assign entry.last_entry     = vo_last_reg;

`ifndef NO_ASSERTIONS
    // last entry of a block is always column three
    a_last_col : assert property (@(posedge clk) disable iff (!rst_n)
        (entry.valid && entry.last_entry) |-> (entry.matrix_address[1:0] == 2'b11))
        else $error("last entry not in column three");

    // a new pair only enters when the previous one has issued everything
    a_accept_gap : assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> (!tok.valid || (adv && tok.idx == LAST_IDX)))
        else $error("pair accepted while entries still pending");

    // an advancing stage hands its valid bit on
    a_adv_shift : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v2_reg) |=> v3_reg)
        else $error("valid bit lost between stages");

    // a stall freezes the pipeline
    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the slater-koster sp hamiltonian block generator:
// atom pairs are sent over the item channel, mostly with random gaps, the sixteen
// matrix entries per pair are predicted in the bench and checked one by one
// against the entry channel, which is stalled at random outside the
// no-gap phase
module testbench import slkb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // generous cycle limit: ~270 pairs x 16 entries, each stalled on both sides
    localparam int CYCLE_LIMIT   = 400000;
    // drain wait after the last entry: pipeline depth plus margin
    localparam int SETTLE_CYCLES = 8;
    // percent of cycles in which each side holds off
    localparam int IDLE_PERCENT  = 37;

    // one predicted matrix entry
    typedef struct {
        logic        [ADDR_W-1:0] addr;
        logic signed [NRG_W-1:0]  value;
        logic                     last;
    } hentry_t;

    logic clk;
    logic rst_n;
    logic              cfg_we;
    logic              cfg_addr;
    logic [NRG_W-1:0]  cfg_wdata;

    slkb_item_if  pair_ch ();
    slkb_entry_if entry_ch ();

    slater_koster_sp_block_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (pair_ch),
        .entry     (entry_ch),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // pairs waiting to be sent, entries waiting to be seen
    item_t   pair_queue[$];
    hentry_t hblock_q[$];

    // bench copy of the on-site energy registers
    logic signed [NRG_W-1:0] onsite_s_mirror;
    logic signed [NRG_W-1:0] onsite_p_mirror;

    bit holding;    // a pair is on the channel and not yet taken
    bit no_gaps;    // both sides run flat out
    bit hold_off;   // sender pauses until the block has drained
    int mismatches;
    int cycle_count;

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // round to nearest (ties up) by dropping sh bits, then clip to q8.12
    function automatic longint round_clip(longint x, int sh);
        longint r;
        r = (x + (longint'(1) << (sh - 1))) >>> sh;
        if (r > longint'(VAL_MAX))
            r = longint'(VAL_MAX);
        if (r < longint'(VAL_MIN))
            r = longint'(VAL_MIN);
        return r;
    endfunction

    // work out the sixteen entries of one pair, in row order
    function automatic void predict_hblock(item_t it);
        longint  c[1:3];
        longint  q[1:3];
        longint  ss, sp, ps, pp, diff, v;
        int      row, col;
        hentry_t e;
        c[1] = $signed(it.cos_x);
        c[2] = $signed(it.cos_y);
        c[3] = $signed(it.cos_z);
        q[1] = it.cos_x_sq;
        q[2] = it.cos_y_sq;
        q[3] = it.cos_z_sq;
        ss   = $signed(it.ss_sigma);
        sp   = $signed(it.sp_sigma);
        ps   = $signed(it.pp_sigma);
        pp   = $signed(it.pp_pi);
        diff = ps - pp;
        for (int k = 0; k < ENTRY_COUNT; k++)
        begin
            row = k / 4;
            col = k % 4;
            if (it.atom_row == it.atom_col)
            begin
                // on-site block: energies on the diagonal only
                if (k == 0)
                    v = onsite_s_mirror;
                else if (row == col)
                    v = onsite_p_mirror;
                else
                    v = 0;
            end
            else if (k == 0)
                v = ss;
            else if (row == 0)
                v = round_clip(c[col] * sp, 14);
            else if (col == 0)
                v = round_clip(-(c[row] * sp), 14);
            else if (row == col)
                v = round_clip(pp * 16384 + q[row] * diff, 14);
            else
                v = round_clip(c[row] * c[col] * diff, 28);
            e.addr  = ADDR_W'(16 * ATOM_COUNT * int'(it.atom_row) + 4 * int'(it.atom_col)
                              + 4 * ATOM_COUNT * row + col);
            e.value = NRG_W'(v);
            e.last  = (k == ENTRY_COUNT - 1);
            hblock_q.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver: pair channel and entry ready change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            pair_ch.valid <= 1'b0;
        else if (holding)
            pair_ch.valid <= 1'b1;   // keep the pair up until it is taken
        else if (pair_queue.size() != 0 && !hold_off
                 && (no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT))
        begin
            pair_ch.valid    <= 1'b1;
            pair_ch.atom_row <= pair_queue[0].atom_row;
            pair_ch.atom_col <= pair_queue[0].atom_col;
            pair_ch.cos_x    <= pair_queue[0].cos_x;
            pair_ch.cos_y    <= pair_queue[0].cos_y;
            pair_ch.cos_z    <= pair_queue[0].cos_z;
            pair_ch.cos_x_sq <= pair_queue[0].cos_x_sq;
            pair_ch.cos_y_sq <= pair_queue[0].cos_y_sq;
            pair_ch.cos_z_sq <= pair_queue[0].cos_z_sq;
            pair_ch.ss_sigma <= pair_queue[0].ss_sigma;
            pair_ch.sp_sigma <= pair_queue[0].sp_sigma;
            pair_ch.pp_sigma <= pair_queue[0].pp_sigma;
            pair_ch.pp_pi    <= pair_queue[0].pp_pi;
            holding = 1'b1;
        end
        else
            pair_ch.valid <= 1'b0;

        // receiver back-pressure
        entry_ch.ready <= rst_n && (no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // pair transaction: predict from the queue head, the pair now on the channel
    always @(posedge clk)
    begin
        if (rst_n && pair_ch.valid && pair_ch.ready)
        begin
            predict_hblock(pair_queue[0]);
            void'(pair_queue.pop_front());
            holding = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each entry transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        hentry_t want;
        if (rst_n && entry_ch.valid && entry_ch.ready)
        begin
            if (hblock_q.size() == 0)
            begin
                $error("entry with nothing predicted: address %0d value %0d",
                       entry_ch.matrix_address, $signed(entry_ch.element_value));
                mismatches++;
            end
            else
            begin
                want = hblock_q.pop_front();
                if (entry_ch.matrix_address !== want.addr)
                begin
                    $error("matrix_address: expected %0d, actual %0d",
                           want.addr, entry_ch.matrix_address);
                    mismatches++;
                end
                if (entry_ch.element_value !== want.value)
                begin
                    $error("element_value: expected %0d, actual %0d",
                           want.value, $signed(entry_ch.element_value));
                    mismatches++;
                end
                if (entry_ch.last_entry !== want.last)
                begin
                    $error("last_entry: expected %0b, actual %0b",
                           want.last, entry_ch.last_entry);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic item_t make_pair(int ai, int aj, int cx, int cy, int cz,
                                        int qx, int qy, int qz,
                                        int ss, int sp, int ps, int pp);
        item_t it;
        it.atom_row = ATOM_W'(ai);
        it.atom_col = ATOM_W'(aj);
        it.cos_x    = COS_W'(cx);
        it.cos_y    = COS_W'(cy);
        it.cos_z    = COS_W'(cz);
        it.cos_x_sq = SQ_W'(qx);
        it.cos_y_sq = SQ_W'(qy);
        it.cos_z_sq = SQ_W'(qz);
        it.ss_sigma = NRG_W'(ss);
        it.sp_sigma = NRG_W'(sp);
        it.pp_sigma = NRG_W'(ps);
        it.pp_pi    = NRG_W'(pp);
        return it;
    endfunction

    function automatic int random_integral();
        // a quarter stay small so rounding is exercised away from the rails
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 16384)) - 8192;
        return int'($urandom_range(0, 1048575)) - 524288;
    endfunction

    // mostly well-formed bonds (squares match the cosines), then
    // independent in-range values, then raw bit patterns
    function automatic item_t random_pair();
        int c[3];
        int q[3];
        int style;
        int ai, aj;
        style = $urandom_range(0, 9);
        ai    = $urandom_range(0, 63);
        if ($urandom_range(0, 99) < 15)
            aj = ai;
        else
        begin
            aj = $urandom_range(0, 63);
            if (aj == ai)
                aj = (ai + 1) % 64;
        end
        for (int a = 0; a < 3; a++)
        begin
            if (style == 9)
            begin
                c[a] = int'($urandom_range(0, 65535)) - 32768;
                q[a] = $urandom_range(0, 32767);
            end
            else
            begin
                c[a] = int'($urandom_range(0, 32768)) - 16384;
                if (style <= 6)
                    q[a] = (c[a] * c[a] + 8192) >>> 14;
                else
                    q[a] = $urandom_range(0, 16384);
            end
        end
        return make_pair(ai, aj, c[0], c[1], c[2], q[0], q[1], q[2],
                         random_integral(), random_integral(),
                         random_integral(), random_integral());
    endfunction

    task automatic write_reg(logic idx, logic [NRG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == REG_ONSITE_S)
            onsite_s_mirror = value;
        else
            onsite_p_mirror = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued pair is sent and every predicted entry has come back
    task automatic drain();
        while (pair_queue.size() != 0 || holding || hblock_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            pair_queue.push_back(random_pair());
    endtask

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = REG_ONSITE_S;
        cfg_wdata       = '0;
        onsite_s_mirror = '0;
        onsite_p_mirror = '0;
        holding         = 1'b0;
        no_gaps         = 1'b0;
        hold_off        = 1'b0;
        mismatches      = 0;
        cycle_count     = 0;
        pair_ch.valid    = 1'b0;
        pair_ch.atom_row = '0;
        pair_ch.atom_col = '0;
        pair_ch.cos_x    = '0;
        pair_ch.cos_y    = '0;
        pair_ch.cos_z    = '0;
        pair_ch.cos_x_sq = '0;
        pair_ch.cos_y_sq = '0;
        pair_ch.cos_z_sq = '0;
        pair_ch.ss_sigma = '0;
        pair_ch.sp_sigma = '0;
        pair_ch.pp_sigma = '0;
        pair_ch.pp_pi    = '0;
        entry_ch.ready   = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // on-site block with energies still at their reset value
        pair_queue.push_back(make_pair(0, 0, 100, -200, 300, 5, 6, 7, 1, 2, 3, 4));
        drain();

        // energies at opposite rails
        write_reg(REG_ONSITE_S, 20'h7FFFF);
        write_reg(REG_ONSITE_P, 20'h80000);
        // highest atom: addresses reach the top of the 16-bit range
        pair_queue.push_back(make_pair(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // geometry and integrals are ignored on-site
        pair_queue.push_back(make_pair(5, 5, -32768, 32767, 16384, 32767, 0, 16384,
                                       524287, -524288, 524287, -524288));
        drain();

        write_reg(REG_ONSITE_S, 20'h80000);
        write_reg(REG_ONSITE_P, 20'h7FFFF);
        pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // bond along x with ordinary integrals
        pair_queue.push_back(make_pair(0, 1, 16384, 0, 0, 16384, 0, 0,
                                       -8000, 6000, 9000, -3000));
        // all cosines at one with integrals at the top rail: entries reach the rails
        pair_queue.push_back(make_pair(63, 0, 16384, 16384, 16384, 16384, 16384, 16384,
                                       524287, 524287, 524287, 524287));
        // all cosines at minus one with integrals at the bottom rail
        pair_queue.push_back(make_pair(0, 63, -16384, -16384, -16384, 16384, 16384, 16384,
                                       -524288, -524288, -524288, -524288));
        // out-of-range cosines and squares, widest sigma-pi spread
        pair_queue.push_back(make_pair(63, 62, -32768, 32767, -32768, 32767, 32767, 32767,
                                       524287, -524288, 524287, -524288));
        pair_queue.push_back(make_pair(17, 42, 32767, -32768, 32767, 32767, 0, 32767,
                                       -524288, 524287, -524288, 524287));
        // zero geometry and zero integrals
        pair_queue.push_back(make_pair(1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // exact halves: ties must round upward on both signs
        pair_queue.push_back(make_pair(3, 4, 8192, -8192, 24576, 8192, 8192, 8192,
                                       1, 1, 1, 0));
        pair_queue.push_back(make_pair(4, 3, -8192, 8192, -24576, 8192, 8192, 8192,
                                       -1, -1, 0, 1));
        // half-length cosines: off-diagonal tie at the 28 bit drop
        pair_queue.push_back(make_pair(10, 20, 8192, 8192, 8192, 4096, 4096, 4096,
                                       300, -300, 2, 0));
        // squares beyond one with opposite sigma and pi
        pair_queue.push_back(make_pair(30, 31, 11585, 11585, 0, 32767, 32767, 0,
                                       1000, -2000, -524288, 524287));
        drain();

        // random part, energies random, both sides idling
        write_reg(REG_ONSITE_S, NRG_W'($urandom()));
        write_reg(REG_ONSITE_P, NRG_W'($urandom()));
        send_random(120);
        drain();

        // long stretch with no gaps on either side
        write_reg(REG_ONSITE_S, NRG_W'($urandom()));
        write_reg(REG_ONSITE_P, NRG_W'($urandom()));
        no_gaps = 1'b1;
        send_random(60);
        drain();
        no_gaps = 1'b0;

        // sender holds off in the middle of a batch until the block empties
        write_reg(REG_ONSITE_S, 20'h00000);
        write_reg(REG_ONSITE_P, NRG_W'($urandom()));
        send_random(35);
        while (pair_queue.size() > 20)
            @(posedge clk);
        hold_off = 1'b1;
        while (holding || hblock_q.size() != 0)
            @(posedge clk);
        hold_off = 1'b0;
        send_random(35);
        drain();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
